>>> hdl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

   // list storage
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);

   // field widths
   localparam int OP_W  = 3;
   localparam int CNT_W = 7;
   localparam int VAL_W = 32;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((CNT_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 1 + CNT_W + VAL_W + CNT_W + 1;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
   localparam logic [OP_W-1:0] OP_GET    = 3'd3;
   localparam logic [OP_W-1:0] OP_DEDUP  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS,
      S_DEL,
      S_FIND,
      S_GET,
      S_DD_LOAD,
      S_DD_CAP,
      S_DD_SCAN,
      S_DD_NEXT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [CNT_W-1:0]        pos;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    valid;
      logic                    ok;
      logic [CNT_W-1:0]        found;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        len;
      logic                    empty;
   } res_type;

endpackage

>>> hdl/ple_ram.sv
`timescale 1ns / 1ps

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ple_seq.sv
`timescale 1ns / 1ps

module ple_seq
   import ple_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req,
   input  logic [CNT_W-1:0] capacity,
   input  logic             rsp_free,
   output logic             idle,
   output res_type          res
);

   state_type               state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ADDR_W-1:0]       ptr_ff, ptr_in;
   logic [ADDR_W-1:0]       end_ff, end_in;
   logic                    up_ff, up_in;
   logic                    issue_ff, issue_in;
   logic                    rd_v_ff, rd_v_in;
   logic [ADDR_W-1:0]       rd_a_ff, rd_a_in;
   logic signed [VAL_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]        w_ff, w_in;
   logic                    ok_ff, ok_in;
   logic [CNT_W-1:0]        found_ff, found_in;
   logic signed [VAL_W-1:0] rv_ff, rv_in;

   logic                    mem_wr_en;
   logic [ADDR_W-1:0]       mem_wr_addr;
   logic [VAL_W-1:0]        mem_wr_data;
   logic                    mem_rd_en;
   logic [ADDR_W-1:0]       mem_rd_addr;
   logic [VAL_W-1:0]        mem_rd_data;

   logic [CNT_W-1:0]        cap_eff;
   logic [ADDR_W-1:0]       req_pos_m1;
   logic [ADDR_W-1:0]       pos_m1;
   logic                    scan_state;

   ple_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign cap_eff    = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
   assign req_pos_m1 = ADDR_W'(req.pos - CNT_W'(1));
   assign pos_m1     = ADDR_W'(pos_ff - CNT_W'(1));
   assign scan_state = (state_ff == S_INS) || (state_ff == S_DEL) || (state_ff == S_FIND) ||
                       (state_ff == S_GET) || (state_ff == S_DD_SCAN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         issue_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         issue_ff <= issue_in;
         rd_v_ff  <= rd_v_in;
      end
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      ptr_ff   <= ptr_in;
      end_ff   <= end_in;
      up_ff    <= up_in;
      rd_a_ff  <= rd_a_in;
      cur_ff   <= cur_in;
      k_ff     <= k_in;
      w_ff     <= w_in;
      ok_ff    <= ok_in;
      found_ff <= found_in;
      rv_ff    <= rv_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      end_in   = end_ff;
      up_in    = up_ff;
      issue_in = issue_ff;
      rd_v_in  = 1'b0;
      rd_a_in  = rd_a_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      w_in     = w_ff;
      ok_in    = ok_ff;
      found_in = found_ff;
      rv_in    = rv_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;

      // issue one read per cycle along the address range
      if (scan_state && issue_ff) begin
         mem_rd_en = 1'b1;
         rd_v_in   = 1'b1;
         rd_a_in   = ptr_ff;
         if (ptr_ff == end_ff) begin
            issue_in = 1'b0;
         end else begin
            ptr_in = up_ff ? ptr_ff + ADDR_W'(1) : ptr_ff - ADDR_W'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req.op;
               pos_in   = req.pos;
               val_in   = req.value;
               ok_in    = 1'b0;
               found_in = '0;
               rv_in    = '0;
               issue_in = 1'b0;
               up_in    = 1'b1;
               state_in = S_DONE;
               case (req.op)
                  OP_INSERT: begin
                     if (req.pos != '0 && req.pos <= cnt_ff + CNT_W'(1) && cnt_ff < cap_eff) begin
                        ptr_in   = ADDR_W'(cnt_ff - CNT_W'(1));
                        end_in   = req_pos_m1;
                        up_in    = 1'b0;
                        issue_in = (req.pos != cnt_ff + CNT_W'(1));
                        state_in = S_INS;
                     end
                  end
                  OP_DELETE: begin
                     if (req.pos != '0 && req.pos <= cnt_ff) begin
                        ptr_in   = req_pos_m1;
                        end_in   = ADDR_W'(cnt_ff - CNT_W'(1));
                        issue_in = 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  OP_FIND: begin
                     ptr_in   = '0;
                     end_in   = ADDR_W'(cnt_ff - CNT_W'(1));
                     issue_in = (cnt_ff != '0);
                     state_in = S_FIND;
                  end
                  OP_GET: begin
                     if (req.pos != '0 && req.pos <= cnt_ff) begin
                        ptr_in   = req_pos_m1;
                        end_in   = req_pos_m1;
                        issue_in = 1'b1;
                        state_in = S_GET;
                     end
                  end
                  OP_DEDUP: begin
                     if (cnt_ff == '0) begin
                        ok_in = 1'b1;
                     end else begin
                        k_in     = '0;
                        w_in     = '0;
                        state_in = S_DD_LOAD;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                     ok_in  = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_INS: begin
            // move each entry up by one, highest first
            if (rd_v_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = rd_a_ff + ADDR_W'(1);
               mem_wr_data = mem_rd_data;
            end
            if (!issue_ff && !rd_v_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_m1;
               mem_wr_data = val_ff;
               cnt_in      = cnt_ff + CNT_W'(1);
               ok_in       = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DEL: begin
            // first word read is the removed value, the rest move down
            if (rd_v_ff) begin
               if (rd_a_ff == pos_m1) begin
                  rv_in = mem_rd_data;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = rd_a_ff - ADDR_W'(1);
                  mem_wr_data = mem_rd_data;
               end
            end
            if (!issue_ff && !rd_v_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_FIND: begin
            if (rd_v_ff && mem_rd_data == val_ff) begin
               found_in = CNT_W'(rd_a_ff) + CNT_W'(1);
               ok_in    = 1'b1;
               issue_in = 1'b0;
               state_in = S_DONE;
            end else if (!issue_ff && !rd_v_ff) begin
               state_in = S_DONE;
            end
         end
         S_GET: begin
            if (rd_v_ff) begin
               rv_in = mem_rd_data;
               ok_in = 1'b1;
            end
            if (!issue_ff && !rd_v_ff) begin
               state_in = S_DONE;
            end
         end
         S_DD_LOAD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = k_ff;
            rd_v_in     = 1'b1;
            rd_a_in     = k_ff;
            state_in    = S_DD_CAP;
         end
         S_DD_CAP: begin
            // hold the candidate and scan the kept prefix for it
            cur_in   = mem_rd_data;
            ptr_in   = '0;
            end_in   = ADDR_W'(w_ff - CNT_W'(1));
            up_in    = 1'b1;
            issue_in = (w_ff != '0);
            state_in = S_DD_SCAN;
         end
         S_DD_SCAN: begin
            if (rd_v_ff && mem_rd_data == cur_ff) begin
               issue_in = 1'b0;
               state_in = S_DD_NEXT;
            end else if (!issue_ff && !rd_v_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ADDR_W'(w_ff);
               mem_wr_data = cur_ff;
               w_in        = w_ff + CNT_W'(1);
               state_in    = S_DD_NEXT;
            end
         end
         S_DD_NEXT: begin
            if (CNT_W'(k_ff) + CNT_W'(1) == cnt_ff) begin
               cnt_in   = w_ff;
               ok_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + ADDR_W'(1);
               state_in = S_DD_LOAD;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle      = (state_ff == S_IDLE);
   assign res.valid = (state_ff == S_DONE);
   assign res.ok    = ok_ff;
   assign res.found = found_ff;
   assign res.value = rv_ff;
   assign res.len   = cnt_ff;
   assign res.empty = (cnt_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("read and write of the same entry in one cycle");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff != S_IDLE && state_ff != S_DONE))
      else $error("store written outside an operation");

   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && op_ff == OP_CLEAR) |-> (cnt_ff == '0))
      else $error("clear left entries");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS && state_in == S_DONE) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("insert did not grow the list by one");

endmodule

>>> hdl/positional_list_engine.sv
`timescale 1ns / 1ps

// Positional list engine: an ordered list of signed 32-bit values, packed
// from position 1, held in one single-port-read, single-port-write RAM.
// Channels:
//   req_*  : one request (operation in tuser; position and value in tdata).
//   rsp_*  : one response per request (ok, found position, value, length,
//            empty flag), held in an output register until taken.
//   csr_*  : write of the capacity register; write only while idle.
// Without a stall the next request is taken in the same cycle as its
// response appears on rsp_*. The bound is the RAM read port: every shift,
// search or compare walks the list one entry per cycle.
// A new request is taken once the previous one has finished, even while its
// response still waits in the output register; the next response then waits
// until the receiver frees that register.
// Reset empties the list and sets capacity to 64; the RAM is not cleared,
// entries beyond the length are never read.
module positional_list_engine
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request tdata, from bit 0: position[6:0], item_value[38:7], zero pad[39]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // request tuser: operation[2:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // response tdata, from bit 0: ok[0], found_position[7:1],
   //                   result_value[39:8], list_length[46:40], is_empty[47]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata
);

   logic [CNT_W-1:0]      capacity_ff, capacity_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   req_type req;
   res_type res;
   logic    seq_idle;
   logic    start;
   logic    rsp_free;

   // unpack the request
   assign req.op    = req_tuser;
   assign req.pos   = req_tdata[CNT_W-1:0];
   assign req.value = req_tdata[CNT_W+VAL_W-1:CNT_W];

   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;

   // output register is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   ple_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .capacity (capacity_ff),
      .rsp_free (rsp_free),
      .idle     (seq_idle),
      .res      (res)
   );

   // capacity register: always ready; the user must write it only between requests, the block does not enforce it
   assign csr_ready   = 1'b1;
   assign capacity_in = csr_valid ? csr_wdata : capacity_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // load a finished response when the register frees up
      if (res.valid && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({res.empty, res.len, res.value, res.found, res.ok});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> tb/positional_list_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_tb;
   import ple_pkg::*;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int CYCLE_LIMIT  = 10_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam int MAX_POS      = (1 << CNT_W) - 1;

   // expected fields of one response
   typedef struct packed {
      logic                    ok;
      logic [CNT_W-1:0]        found;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        len;
      logic                    empty;
   } list_outcome_type;

   // receiver behaviour, switched between the modes below
   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_BLOCKS
   } sink_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // request tdata: position[6:0], item_value[38:7], zero pad[39]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // request tuser: operation[2:0]
   logic [OP_W-1:0]       req_tuser  = OP_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // response tdata: ok[0], found_position[7:1], result_value[39:8],
   // list_length[46:40], is_empty[47]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_wdata  = '0;

   // shadow of the list as the block should hold it
   logic signed [VAL_W-1:0] list_entries [DEPTH];
   int                      list_len      = 0;
   int                      list_capacity = DEPTH;

   req_type          request_q [$];
   list_outcome_type outcome_q [$];

   int            error_count = 0;
   bit            req_taken   = 1'b0;
   int            burst_left  = 0;
   int            gap_left    = 0;
   sink_mode_type sink_mode   = SINK_OPEN;
   int            sink_left   = 0;

   positional_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Apply one request to the shadow list and return the response it owes.
   // Positions are 1-based; anything outside the valid window leaves the
   // list untouched and reports ok low.
   function automatic list_outcome_type apply_request(input logic [OP_W-1:0] op,
         input logic [CNT_W-1:0] pos, input logic signed [VAL_W-1:0] val);
      list_outcome_type r;
      int               p, room, k, m, kept;
      bit               dup;
      r    = '0;
      p    = int'(pos);
      // capacity saturates at the depth of the store
      room = (list_capacity > DEPTH) ? DEPTH : list_capacity;
      case (op)
         OP_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < room) begin
               for (k = list_len; k > p - 1; k--)
                  list_entries[k] = list_entries[k - 1];
               list_entries[p - 1] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         OP_DELETE: begin
            if (p >= 1 && p <= list_len) begin
               r.value = list_entries[p - 1];
               for (k = p - 1; k + 1 < list_len; k++)
                  list_entries[k] = list_entries[k + 1];
               list_len--;
               r.ok = 1'b1;
            end
         end
         OP_FIND: begin
            for (k = 0; k < list_len && !r.ok; k++) begin
               if (list_entries[k] == val) begin
                  r.found = CNT_W'(k + 1);
                  r.ok    = 1'b1;
               end
            end
         end
         OP_GET: begin
            if (p >= 1 && p <= list_len) begin
               r.value = list_entries[p - 1];
               r.ok    = 1'b1;
            end
         end
         OP_DEDUP: begin
            // compact in place, keeping the first copy of each value
            kept = 0;
            for (k = 0; k < list_len; k++) begin
               dup = 1'b0;
               for (m = 0; m < kept; m++)
                  if (list_entries[m] == list_entries[k]) dup = 1'b1;
               if (!dup) begin
                  list_entries[kept] = list_entries[k];
                  kept++;
               end
            end
            list_len = kept;
            r.ok     = 1'b1;
         end
         OP_CLEAR: begin
            list_len = 0;
            r.ok     = 1'b1;
         end
         default: begin
         end
      endcase
      r.len   = CNT_W'(list_len);
      r.empty = (list_len == 0);
      return r;
   endfunction

   // Values: a small pool so that finds hit and repeats pile up, extremes,
   // and fully random words.
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'sh8000_0000;
         1: v = 32'sh7FFF_FFFF;
         2: v = -32'sd1;
         3, 4, 5: v = $urandom_range(0, 5);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Positions: mostly inside the list, some at zero or beyond the end.
   function automatic logic [CNT_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15)
         return CNT_W'($urandom_range(1, list_len + 1));
      else if (r < 17)
         return '0;
      else if (r < 19)
         return CNT_W'($urandom_range(list_len + 1, MAX_POS));
      else
         return CNT_W'($urandom_range(0, MAX_POS));
   endfunction

   function automatic req_type random_request(input int insert_pct, input bit allow_clear);
      req_type q;
      int      r;
      q.value = pick_value();
      q.pos   = pick_position();
      if ($urandom_range(0, 99) < insert_pct) begin
         q.op = OP_INSERT;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 25)      q.op = OP_DELETE;
         else if (r < 50) q.op = OP_FIND;
         else if (r < 75) q.op = OP_GET;
         else if (r < 85) q.op = OP_DEDUP;
         else if (r < 90) q.op = allow_clear ? OP_CLEAR : OP_GET;
         else if (r < 95) q.op = OP_SPARE_A;
         else             q.op = OP_SPARE_B;
      end
      return q;
   endfunction

   function automatic void queue_request(input logic [OP_W-1:0] op,
         input logic [CNT_W-1:0] pos, input logic signed [VAL_W-1:0] val);
      req_type q;
      q.op    = op;
      q.pos   = pos;
      q.value = val;
      request_q.push_back(q);
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%s", msg);
   endfunction

   // Hold until every request has gone and every response has come back.
   task automatic wait_drained();
      do @(posedge clock);
      while (request_q.size() != 0 || req_tvalid || outcome_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Keep the request queue short so that positions track the live length.
   task automatic run_phase(input int count, input int insert_pct, input bit allow_clear);
      int n;
      for (n = 0; n < count; n++) begin
         while (request_q.size() >= 4) @(posedge clock);
         request_q.push_back(random_request(insert_pct, allow_clear));
      end
      wait_drained();
   endtask

   // Sender: bursts of requests separated by random gaps. A request stays
   // on the bus until taken.
   always @(negedge clock) begin
      req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (request_q.size() > 0) begin
            next_req = request_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, next_req.value, next_req.pos};
            req_tuser  <= next_req.op;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // start a fresh burst; one in four runs straight on
               burst_left = $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: switch between always ready, coin-flip, sparse and a
   // blocky on/off pattern.
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_left = $urandom_range(32, 300);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         SINK_OPEN:   rsp_tready <= 1'b1;
         SINK_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         SINK_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:     rsp_tready <= sink_left[3];
      endcase
   end

   // Sample every handshake at the rising edge: predict on request, check
   // on response, track capacity on register write.
   always @(posedge clock) begin
      list_outcome_type want, got;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken)
         outcome_q.push_back(apply_request(req_tuser, req_tdata[CNT_W-1:0],
                                           req_tdata[CNT_W+VAL_W-1:CNT_W]));
      if (!reset && csr_valid && csr_ready)
         list_capacity = int'(csr_wdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tdata[0];
         got.found = rsp_tdata[CNT_W:1];
         got.value = rsp_tdata[CNT_W+VAL_W:CNT_W+1];
         got.len   = rsp_tdata[2*CNT_W+VAL_W:CNT_W+VAL_W+1];
         got.empty = rsp_tdata[2*CNT_W+VAL_W+1];
         if (outcome_q.size() == 0) begin
            note_error($sformatf("%0t: response with no request waiting", $realtime));
         end else begin
            want = outcome_q.pop_front();
            if (got.ok !== want.ok || got.found !== want.found ||
                got.value !== want.value || got.len !== want.len ||
                got.empty !== want.empty)
               note_error($sformatf(
                  "%0t: mismatch ok/found/value/len/empty exp %0b/%0d/%0d/%0d/%0b got %0b/%0d/%0d/%0d/%0b",
                  $realtime, want.ok, want.found, want.value, want.len, want.empty,
                  got.ok, got.found, got.value, got.len, got.empty));
         end
      end
   end

   // Stop a hung run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("positional_list_engine_tb: FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty list, bad positions, extremes, repeats, spare codes.
      queue_request(OP_GET,     7'd1,   32'sd0);
      queue_request(OP_DELETE,  7'd1,   32'sd0);
      queue_request(OP_FIND,    7'd0,   32'sd0);
      queue_request(OP_DEDUP,   7'd0,   32'sd0);
      queue_request(OP_INSERT,  7'd0,   32'sd9);
      queue_request(OP_INSERT,  7'd2,   32'sd9);
      queue_request(OP_INSERT,  7'd1,   32'sh8000_0000);
      queue_request(OP_INSERT,  7'd2,   32'sh7FFF_FFFF);
      queue_request(OP_INSERT,  7'd1,   -32'sd1);
      queue_request(OP_INSERT,  7'd4,   32'sd0);
      queue_request(OP_FIND,    7'd0,   32'sh7FFF_FFFF);
      queue_request(OP_FIND,    7'd127, 32'sd12345);
      queue_request(OP_GET,     7'd4,   32'sd0);
      queue_request(OP_GET,     7'd5,   32'sd0);
      queue_request(OP_GET,     7'd127, 32'sd0);
      queue_request(OP_INSERT,  7'd1,   -32'sd1);
      queue_request(OP_INSERT,  7'd3,   32'sd0);
      queue_request(OP_DEDUP,   7'd0,   32'sd0);
      queue_request(OP_DELETE,  7'd1,   32'sd0);
      queue_request(OP_DELETE,  7'd65,  32'sd0);
      queue_request(OP_SPARE_A, 7'd1,   32'sd1);
      queue_request(OP_SPARE_B, 7'd1,   32'sd1);
      queue_request(OP_CLEAR,   7'd0,   32'sd0);
      queue_request(OP_GET,     7'd1,   32'sd0);
      wait_drained();

      // Above the depth: fill the store completely and hit the full case.
      write_capacity(7'd127);
      run_phase(200, 85, 1'b0);
      // Drop capacity below the length: entries stay, inserts are refused.
      write_capacity(7'd10);
      run_phase(100, 50, 1'b0);
      write_capacity(7'd0);
      run_phase(80, 40, 1'b1);
      write_capacity(7'd1);
      run_phase(150, 40, 1'b1);
      write_capacity(7'd64);
      run_phase(400, 40, 1'b1);
      write_capacity(7'd3);
      run_phase(150, 40, 1'b1);
      write_capacity(7'd33);
      run_phase(400, 45, 1'b1);

      repeat (64) @(posedge clock);
      if (error_count == 0 && outcome_q.size() == 0) begin
         $display("positional_list_engine_tb: PASS");
      end else begin
         $display("positional_list_engine_tb: FAIL");
      end
      $finish;
   end

endmodule
